@@ rtl/sbar_pkg.sv @@
// ----------------------------------------------------------------------------
// sbar_pkg
// Shared types and constants of the serial bit-addressed ram unit.
// ----------------------------------------------------------------------------
package sbar_pkg;

  localparam int MEM_BYTES_DEF = 8192;
  localparam int BYTE_W        = 8;
  localparam int BIT_W         = 3;

  localparam logic [BIT_W-1:0]  LAST_BIT = 3'd7;
  localparam logic [BYTE_W-1:0] BIT0_MASK = 8'h01;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  // access kind carried on in_tuser
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } sbar_state_t;

endpackage

@@ rtl/serial_bit_addressed_ram_unit.sv @@
// ----------------------------------------------------------------------------
// serial_bit_addressed_ram_unit
// Byte memory reached one bit at a time through a byte address and a bit
// pointer, with write, advance and latched read-back of the selected bit.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                     | tuser | function
//  in_     | slave     | port, keep, we, wdata     | kind  | write / read access
//  out_    | master    | rd_bit                    | -     | one result per beat
//
// one item at a time: the accept cycle of a write access issues the byte read,
// the busy state gets the ram read data back and, with wr_en, writes the modified byte
// after reset a clear pass writes zero to all MEM_BYTES bytes, with in_tready low
// a stalled result holds the busy cycle until out_tready; the next beat may be
// taken while the result still waits
module serial_bit_addressed_ram_unit #(
  parameter int MEM_BYTES = sbar_pkg::MEM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] port_select [1] keep_position
                                 // [2] wr_en [3] write_data, rest zero
  input  logic       in_tuser,   // [0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] rd_bit, rest zero
);

  import sbar_pkg::*;

  localparam int ADDR_W = $clog2(MEM_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_BYTES - 1);

  sbar_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BIT_W-1:0]  ptr_r, ptr_nxt;
  logic              last_we_r, last_we_nxt;
  logic              latched_r, latched_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_bit_r, out_bit_nxt;

  // item fields held for the busy cycle
  logic kind_r, port_r, we_r, wd_r;

  logic              in_beat;
  logic              done;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_rdata;
  logic [BYTE_W-1:0] bit_mask;
  logic [BYTE_W-1:0] mod_byte;
  logic [ADDR_W-1:0] base_addr;
  logic [BIT_W-1:0]  base_ptr;
  logic              advance;

  assign in_beat  = in_tvalid && in_tready;
  assign done     = !out_valid_r || out_tready;
  assign bit_mask = BIT0_MASK << ptr_r;
  assign mod_byte = (mem_rdata & ~bit_mask) | (wd_r ? bit_mask : ZERO_BYTE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // state-dependent controls
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = mod_byte;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = ZERO_BYTE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_BUSY: begin
        mem_we = done && (kind_r == KIND_WRITE) && we_r;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // pointer update of a write access, resolved at the accept
  always_comb begin
    base_addr   = in_tdata[1] ? addr_r : '0;
    base_ptr    = in_tdata[1] ? ptr_r : '0;
    advance     = !in_tdata[2] && last_we_r;
    addr_nxt    = addr_r;
    ptr_nxt     = ptr_r;
    last_we_nxt = last_we_r;
    mem_re      = 1'b0;
    if (in_beat && (in_tuser == KIND_WRITE)) begin
      mem_re      = 1'b1;
      last_we_nxt = in_tdata[2];
      addr_nxt    = base_addr;
      ptr_nxt     = base_ptr;
      if (advance) begin
        if (base_ptr == LAST_BIT) begin
          ptr_nxt  = '0;
          addr_nxt = (base_addr == LAST_ADDR) ? '0 : base_addr + 1'b1;
        end else begin
          ptr_nxt = base_ptr + 1'b1;
        end
      end
    end
  end

  // result and latched bit
  always_comb begin
    latched_nxt   = latched_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;
    clr_cnt_nxt   = (state_r == ST_CLEAR) ? clr_cnt_r + 1'b1 : clr_cnt_r;
    if ((state_r == ST_BUSY) && done) begin
      out_valid_nxt = 1'b1;
      if (kind_r == KIND_WRITE) begin
        latched_nxt = we_r ? wd_r : mem_rdata[ptr_r];
        out_bit_nxt = 1'b0;
      end else begin
        out_bit_nxt = port_r ? latched_r : 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      ptr_r       <= '0;
      last_we_r   <= 1'b0;
      latched_r   <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      ptr_r       <= ptr_nxt;
      last_we_r   <= last_we_nxt;
      latched_r   <= latched_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r <= out_bit_nxt;
    if (in_beat) begin
      kind_r <= in_tuser;
      port_r <= in_tdata[0];
      we_r   <= in_tdata[2];
      wd_r   <= in_tdata[3];
    end
  end

  sbar_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_nxt),
    .rdata (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r};

endmodule

@@ rtl/sbar_ram.sv @@
// ----------------------------------------------------------------------------
// sbar_ram
// Generic single-write, single-read synchronous ram with registered read.
// ----------------------------------------------------------------------------
module sbar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sbar_checker.sv @@
// ----------------------------------------------------------------------------
// sbar_checker
// Port-level checks of the serial bit-addressed ram unit, bound to the top.
// ----------------------------------------------------------------------------
module sbar_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  import sbar_pkg::*;

  // a waiting result beat stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped before it was taken");

  // one item at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in two consecutive cycles");

  // write access or read of port zero, taken with no result waiting, returns a zero bit
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid &&
    ((in_tuser == KIND_WRITE) || (in_tdata[0] == 1'b0))
    |-> ##2 (out_tvalid && (out_tdata[0] == 1'b0)))
    else $error("write or port-zero read returned a set bit");

  // clear pass holds off input and output after reset
  assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("beat possible right after reset");

endmodule

bind serial_bit_addressed_ram_unit sbar_checker u_sbar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
